// ----- sv/hksg_pkg.sv -----
// hksg_pkg: types, fixed-point constants and helpers for the haptic knob
// setpoint generator. No dependencies; every other file but hksg_if imports it.
package hksg_pkg;

    localparam int FRAC_BITS = 16;

    // fixed-point constants, rounded to nearest at elaboration
    localparam longint FX_ONE    = longint'(1) << FRAC_BITS;
    localparam longint FX_0P3    = (3 * FX_ONE + 5) / 10;
    localparam longint FX_4P2    = (42 * FX_ONE + 5) / 10;
    localparam longint FX_20     = 20 * FX_ONE;
    localparam longint FX_5P1    = (51 * FX_ONE + 5) / 10;
    localparam longint FX_3P3    = (33 * FX_ONE + 5) / 10;
    localparam longint FX_DETENT = (64'sd5235987756 * FX_ONE + 64'sd5000000000)
                                   / 64'sd10000000000;

    localparam logic signed [31:0] FX_ONE_S     = 32'(FX_ONE);
    localparam logic signed [31:0] FX_NEG_ONE_S = 32'(-FX_ONE);
    localparam logic signed [32:0] FX_0P3_S     = 33'(FX_0P3);
    localparam logic signed [31:0] FX_4P2_S     = 32'(FX_4P2);
    localparam logic signed [31:0] FX_20_S      = 32'(FX_20);
    localparam logic signed [31:0] FX_5P1_S     = 32'(FX_5P1);
    localparam logic signed [31:0] FX_3P3_S     = 32'(FX_3P3);
    localparam logic [18:0]        FX_DETENT_S  = 19'(FX_DETENT);

    // register map, word index
    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_OPERATING_MODE = 3'd0,
        REG_ZERO_OFFSET    = 3'd1,
        REG_LIMIT_UPPER    = 3'd2,
        REG_LIMIT_LOWER    = 3'd3,
        REG_DETENT_STEP    = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_DISABLE = 3'd0,
        OP_INERTIA = 3'd1,
        OP_ENCODER = 3'd2,
        OP_SPRING  = 3'd3,
        OP_DAMPED  = 3'd4,
        OP_SPIN    = 3'd5
    } t_op_mode;

    typedef enum logic [1:0] {
        DRV_TORQUE   = 2'd0,
        DRV_VELOCITY = 2'd1,
        DRV_ANGLE    = 2'd2
    } t_drive_mode;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [2:0]         operating_mode;
        logic signed [31:0] zero_offset;
        logic signed [31:0] limit_upper;
        logic signed [31:0] limit_lower;
        logic [18:0]        detent_step;
    } t_cfg;

    typedef struct packed {
        logic               command;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
    } t_req;

    typedef struct packed {
        logic               motor_enable;
        logic [1:0]         drive_mode;
        logic signed [31:0] setpoint;
        logic [2:0]         gain_profile;
        logic signed [31:0] detent_count;
        logic signed [31:0] position;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/hksg_if.sv -----
// hksg_if: valid/ready channel interfaces for requests and results.
// No dependencies.
interface hksg_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_velocity;

    modport source(output valid, command, measured_angle, measured_velocity, input ready);
    modport sink(input valid, command, measured_angle, measured_velocity, output ready);
endinterface

interface hksg_out_if;
    logic               valid;
    logic               ready;
    logic               motor_enable;
    logic [1:0]         drive_mode;
    logic signed [31:0] setpoint;
    logic [2:0]         gain_profile;
    logic signed [31:0] detent_count;
    logic signed [31:0] position;

    modport source(output valid, motor_enable, drive_mode, setpoint, gain_profile,
                   detent_count, position, input ready);
    modport sink(input valid, motor_enable, drive_mode, setpoint, gain_profile,
                 detent_count, position, output ready);
endinterface

// ----- sv/hksg_cfg_regs.sv -----
// hksg_cfg_regs: APB-style configuration register file.
// Depends on hksg_pkg.
module hksg_cfg_regs
    import hksg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    t_reg_idx   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.operating_mode <= OP_DISABLE;
            r_cfg.zero_offset    <= '0;
            r_cfg.limit_upper    <= FX_5P1_S;
            r_cfg.limit_lower    <= FX_3P3_S;
            r_cfg.detent_step    <= FX_DETENT_S;
        end else if (wr_en) begin
            unique case (idx)
                REG_OPERATING_MODE: r_cfg.operating_mode <= pwdata[2:0];
                REG_ZERO_OFFSET:    r_cfg.zero_offset    <= pwdata;
                REG_LIMIT_UPPER:    r_cfg.limit_upper    <= pwdata;
                REG_LIMIT_LOWER:    r_cfg.limit_lower    <= pwdata;
                REG_DETENT_STEP:    r_cfg.detent_step    <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_OPERATING_MODE: prdata = {29'd0, r_cfg.operating_mode};
            REG_ZERO_OFFSET:    prdata = r_cfg.zero_offset;
            REG_LIMIT_UPPER:    prdata = r_cfg.limit_upper;
            REG_LIMIT_LOWER:    prdata = r_cfg.limit_lower;
            REG_DETENT_STEP:    prdata = {13'd0, r_cfg.detent_step};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- sv/hksg_in_stage.sv -----
// hksg_in_stage: input register; forms the saturated position on the way in.
// Depends on hksg_pkg.
module hksg_in_stage
    import hksg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_angle,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_zero_offset,
    input  logic               i_down_ready,
    output logic               o_valid,
    output t_req               o_req
);

    logic r_valid;
    t_req r_req;
    logic accept;
    logic signed [32:0] pos_diff;

    assign o_ready  = !r_valid || i_down_ready;
    assign accept   = i_valid && o_ready;
    assign pos_diff = {i_angle[31], i_angle} - {i_zero_offset[31], i_zero_offset};
    assign o_valid  = r_valid;
    assign o_req    = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.command  <= i_command;
            r_req.position <= sat32(pos_diff);
            r_req.velocity <= i_velocity;
        end
    end

endmodule

// ----- sv/hksg_update.sv -----
// hksg_update: haptic mode state, next-state logic and result register.
// Depends on hksg_pkg.
module hksg_update
    import hksg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_res o_res
);

    logic signed [31:0] r_target,     n_target;
    logic signed [31:0] r_prev_angle, n_prev_angle;
    logic signed [31:0] r_prev_vel,   n_prev_vel;
    logic signed [31:0] r_count,      n_count;
    t_drive_mode        r_drive,      n_drive;
    logic               r_drive_on,   n_drive_on;
    logic [2:0]         r_profile,    n_profile;
    logic               r_out_valid;
    t_res               r_res;

    logic               adv;
    logic signed [32:0] vel_diff, vel_diff_abs;
    logic signed [32:0] ang_diff, half, neg_half;
    logic signed [32:0] step_up, step_dn;
    logic               limits_on;
    t_op_mode           op;

    assign o_ready     = !r_out_valid || i_out_ready;
    assign adv         = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign op          = t_op_mode'(i_cfg.operating_mode);

    assign vel_diff     = {i_req.velocity[31], i_req.velocity} - {r_prev_vel[31], r_prev_vel};
    assign vel_diff_abs = vel_diff[32] ? -vel_diff : vel_diff;
    assign ang_diff     = {i_req.position[31], i_req.position}
                          - {r_prev_angle[31], r_prev_angle};
    assign half         = {15'd0, i_cfg.detent_step[18:1]};
    assign neg_half     = -half;
    assign step_up      = {r_target[31], r_target} + {14'd0, i_cfg.detent_step};
    assign step_dn      = {r_target[31], r_target} - {14'd0, i_cfg.detent_step};
    assign limits_on    = (i_cfg.limit_upper != 0) && (i_cfg.limit_lower != 0);

    always_comb begin
        n_target     = r_target;
        n_prev_angle = r_prev_angle;
        n_prev_vel   = r_prev_vel;
        n_count      = r_count;
        n_drive      = r_drive;
        n_drive_on   = r_drive_on;
        n_profile    = r_profile;
        if (i_req.command == CMD_START) begin
            n_prev_angle = i_req.position;
            n_prev_vel   = i_req.velocity;
            unique case (op)
                OP_INERTIA: begin
                    n_drive_on = 1'b1;
                    n_drive    = DRV_VELOCITY;
                    n_profile  = OP_INERTIA;
                end
                OP_ENCODER: begin
                    n_drive_on   = 1'b1;
                    n_drive      = DRV_ANGLE;
                    n_profile    = OP_ENCODER;
                    n_target     = FX_4P2_S;
                    n_prev_angle = FX_4P2_S;
                end
                OP_SPRING: begin
                    n_drive_on = 1'b1;
                    n_drive    = DRV_ANGLE;
                    n_profile  = OP_SPRING;
                    n_target   = FX_4P2_S;
                end
                OP_DAMPED: begin
                    n_drive_on = 1'b1;
                    n_drive    = DRV_VELOCITY;
                    n_profile  = OP_DAMPED;
                    n_target   = '0;
                end
                OP_SPIN: begin
                    n_drive_on = 1'b1;
                    n_drive    = DRV_VELOCITY;
                    n_profile  = OP_SPIN;
                    n_target   = FX_20_S;
                end
                default: n_drive_on = 1'b0;
            endcase
        end else begin
            unique case (op)
                OP_INERTIA: begin
                    if (i_req.velocity > FX_ONE_S || i_req.velocity < FX_NEG_ONE_S) begin
                        if (vel_diff_abs > FX_0P3_S) begin
                            n_target = i_req.velocity;
                        end
                    end else begin
                        n_target = '0;
                    end
                    n_prev_vel = i_req.velocity;
                end
                OP_ENCODER: begin
                    priority if (ang_diff > half) begin
                        n_target     = sat32(step_up);
                        n_prev_angle = sat32(step_up);
                        n_count      = r_count + 32'sd1;
                    end else if (ang_diff < neg_half) begin
                        n_target     = sat32(step_dn);
                        n_prev_angle = sat32(step_dn);
                        n_count      = r_count - 32'sd1;
                    end
                end
                OP_DAMPED: begin
                    if (limits_on) begin
                        // upper test wins when the limits are inverted
                        priority if (i_req.position > i_cfg.limit_upper) begin
                            n_drive  = DRV_ANGLE;
                            n_target = i_cfg.limit_upper;
                        end else if (i_req.position < i_cfg.limit_lower) begin
                            n_drive  = DRV_ANGLE;
                            n_target = i_cfg.limit_lower;
                        end else begin
                            n_drive  = DRV_VELOCITY;
                            n_target = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_prev_angle <= '0;
            r_prev_vel   <= '0;
            r_count      <= '0;
            r_drive      <= DRV_TORQUE;
            r_drive_on   <= 1'b0;
            r_profile    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_target     <= n_target;
                r_prev_angle <= n_prev_angle;
                r_prev_vel   <= n_prev_vel;
                r_count      <= n_count;
                r_drive      <= n_drive;
                r_drive_on   <= n_drive_on;
                r_profile    <= n_profile;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res.motor_enable <= n_drive_on;
            r_res.drive_mode   <= n_drive;
            r_res.setpoint     <= n_target;
            r_res.gain_profile <= n_profile;
            r_res.detent_count <= n_count;
            r_res.position     <= i_req.position;
        end
    end

endmodule

// ----- sv/haptic_knob_setpoint_generator_core.sv -----
// Haptic knob setpoint generator. Each request (control tick or mode start)
// yields exactly one result: motor enable, drive mode, setpoint, gain profile,
// detent count and offset-corrected position. The result passes through the input
// register, then the mode-update logic feeding the result register; a new request
// is taken every cycle while results are drained. Registers are to be written over
// the APB port only while no request is in flight; the user is bound to this, the
// block itself does not enforce it. pready is always high.
// Depends on hksg_pkg, hksg_if, hksg_cfg_regs, hksg_in_stage, hksg_update.
module haptic_knob_setpoint_generator_core
    import hksg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hksg_in_if.sink           i_in,
    hksg_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg cfg;
    t_req req;
    t_res res;
    logic req_valid;
    logic upd_ready;
    logic out_valid;

    hksg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hksg_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_command     (i_in.command),
        .i_angle       (i_in.measured_angle),
        .i_velocity    (i_in.measured_velocity),
        .i_zero_offset (cfg.zero_offset),
        .i_down_ready  (upd_ready),
        .o_valid       (req_valid),
        .o_req         (req)
    );

    hksg_update u_upd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (req_valid),
        .i_req       (req),
        .o_ready     (upd_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign o_out.valid        = out_valid;
    assign o_out.motor_enable = res.motor_enable;
    assign o_out.drive_mode   = res.drive_mode;
    assign o_out.setpoint     = res.setpoint;
    assign o_out.gain_profile = res.gain_profile;
    assign o_out.detent_count = res.detent_count;
    assign o_out.position     = res.position;

endmodule

// ----- bench/haptic_knob_setpoint_generator_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for haptic_knob_setpoint_generator_core: drives control ticks and
// mode starts, predicts each setpoint result and checks it field by field.
// Depends on hksg_pkg, hksg_if and the core with its submodules.
module haptic_knob_setpoint_generator_core_tb;
    import hksg_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] angle;
        logic signed [31:0] velocity;
    } t_knob_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    hksg_in_if  req_if();
    hksg_out_if res_if();

    haptic_knob_setpoint_generator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_knob_req pending_reqs[$];
    t_res      expected_setpoints[$];
    t_knob_req next_req;
    t_res      want;
    int        fail_count;
    int        idle_cycles;
    bit        no_gaps;

    // register shadow
    logic [2:0]         cfg_mode;
    logic signed [31:0] cfg_offset;
    logic signed [31:0] cfg_upper;
    logic signed [31:0] cfg_lower;
    logic [18:0]        cfg_step;

    // knob state shadow
    logic signed [31:0] sp_target;
    logic signed [31:0] last_pos;
    logic signed [31:0] last_vel;
    logic [31:0]        detents;
    t_drive_mode        drv;
    logic               drive_en;
    logic [2:0]         profile;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7fff_ffff)) begin
            return 32'sh7fff_ffff;
        end
        if (v < -longint'(32'sh7fff_ffff) - 1) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint rand_span(input longint span);
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    function automatic void push_req(input t_cmd c, input logic [31:0] a, input logic [31:0] v);
        t_knob_req r;
        r.cmd      = c;
        r.angle    = a;
        r.velocity = v;
        pending_reqs.push_back(r);
    endfunction

    task automatic reset_knob_model();
        cfg_mode   = OP_DISABLE;
        cfg_offset = '0;
        cfg_upper  = FX_5P1_S;
        cfg_lower  = FX_3P3_S;
        cfg_step   = FX_DETENT_S;
        sp_target  = '0;
        last_pos   = '0;
        last_vel   = '0;
        detents    = '0;
        drv        = DRV_TORQUE;
        drive_en   = 1'b0;
        profile    = '0;
    endtask

    task automatic predict_knob(input t_cmd cmd, input logic signed [31:0] ang,
                                input logic signed [31:0] vel);
        logic signed [31:0] pos;
        longint             diff;
        longint             half;
        t_res               r;
        pos = clamp32(longint'(ang) - longint'(cfg_offset));
        if (cmd == CMD_START) begin
            last_pos = pos;
            last_vel = vel;
            case (cfg_mode)
                OP_INERTIA: begin
                    drive_en = 1'b1; drv = DRV_VELOCITY; profile = OP_INERTIA;
                end
                OP_ENCODER: begin
                    drive_en = 1'b1; drv = DRV_ANGLE; profile = OP_ENCODER;
                    sp_target = FX_4P2_S;
                    last_pos  = FX_4P2_S;
                end
                OP_SPRING: begin
                    drive_en = 1'b1; drv = DRV_ANGLE; profile = OP_SPRING;
                    sp_target = FX_4P2_S;
                end
                OP_DAMPED: begin
                    drive_en = 1'b1; drv = DRV_VELOCITY; profile = OP_DAMPED;
                    sp_target = '0;
                end
                OP_SPIN: begin
                    drive_en = 1'b1; drv = DRV_VELOCITY; profile = OP_SPIN;
                    sp_target = FX_20_S;
                end
                default: begin
                    drive_en = 1'b0;
                end
            endcase
        end else begin
            case (cfg_mode)
                OP_INERTIA: begin
                    if (longint'(vel) > FX_ONE || longint'(vel) < -FX_ONE) begin
                        diff = longint'(vel) - longint'(last_vel);
                        if (diff < 0) begin
                            diff = -diff;
                        end
                        if (diff > FX_0P3) begin
                            sp_target = vel;
                        end
                    end else begin
                        sp_target = '0;
                    end
                    last_vel = vel;
                end
                OP_ENCODER: begin
                    diff = longint'(pos) - longint'(last_pos);
                    half = longint'(cfg_step >> 1);
                    if (diff > half) begin
                        sp_target = clamp32(longint'(sp_target) + longint'(cfg_step));
                        last_pos  = sp_target;
                        detents   = detents + 32'd1;
                    end else if (diff < -half) begin
                        sp_target = clamp32(longint'(sp_target) - longint'(cfg_step));
                        last_pos  = sp_target;
                        detents   = detents - 32'd1;
                    end
                end
                OP_DAMPED: begin
                    // limits only act when both are nonzero; upper test wins if inverted
                    if (cfg_upper != 0 && cfg_lower != 0) begin
                        if (pos > cfg_upper) begin
                            drv = DRV_ANGLE; sp_target = cfg_upper;
                        end else if (pos < cfg_lower) begin
                            drv = DRV_ANGLE; sp_target = cfg_lower;
                        end else begin
                            drv = DRV_VELOCITY; sp_target = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        r.motor_enable = drive_en;
        r.drive_mode   = drv;
        r.setpoint     = sp_target;
        r.gain_profile = profile;
        r.detent_count = detents;
        r.position     = pos;
        expected_setpoints.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, got_val);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(32'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OPERATING_MODE: cfg_mode   = value[2:0];
            REG_ZERO_OFFSET:    cfg_offset = value;
            REG_LIMIT_UPPER:    cfg_upper  = value;
            REG_LIMIT_LOWER:    cfg_lower  = value;
            REG_DETENT_STEP:    cfg_step   = value[18:0];
            default: begin
            end
        endcase
    endtask

    task automatic write_all(input logic [2:0] mode, input logic [31:0] off,
                             input logic [31:0] up, input logic [31:0] lo,
                             input logic [18:0] step_val);
        write_reg(REG_OPERATING_MODE, 32'(mode));
        write_reg(REG_ZERO_OFFSET, off);
        write_reg(REG_LIMIT_UPPER, up);
        write_reg(REG_LIMIT_LOWER, lo);
        write_reg(REG_DETENT_STEP, 32'(step_val));
    endtask

    // returns at a falling edge once no request is queued, in flight or unanswered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_setpoints.size() != 0);
    endtask

    task automatic random_phase(input int n_ticks, input bit pause_mid);
        logic [2:0]         mode;
        logic signed [31:0] off;
        logic signed [31:0] up;
        logic signed [31:0] lo;
        logic [18:0]        step_val;
        longint             center;
        longint             stride;
        longint             walk_pos;
        longint             walk_vel;
        int                 pick;
        int                 k;
        wait_drained();
        pick = $urandom_range(99);
        if (pick < 25) begin
            mode = OP_ENCODER;
        end else if (pick < 45) begin
            mode = OP_INERTIA;
        end else if (pick < 65) begin
            mode = OP_DAMPED;
        end else if (pick < 72) begin
            mode = OP_SPRING;
        end else if (pick < 79) begin
            mode = OP_SPIN;
        end else if (pick < 86) begin
            mode = OP_DISABLE;
        end else begin
            mode = 3'($urandom_range(7));
        end
        off = ($urandom_range(9) == 0) ? $urandom() : 32'(rand_span(8 * FX_ONE));
        case ($urandom_range(9))
            0: begin
                up = '0;
                lo = 32'(rand_span(6 * FX_ONE));
            end
            1: begin
                lo = '0;
                up = 32'(rand_span(6 * FX_ONE));
            end
            2: begin
                up = 32'(rand_span(6 * FX_ONE));
                lo = 32'(longint'(up) + longint'($urandom_range(32'(2 * FX_ONE), 1)));
            end
            3: begin
                up = 32'sh7fff_ffff;
                lo = 32'sh8000_0000;
            end
            default: begin
                lo = 32'(rand_span(6 * FX_ONE));
                up = 32'(longint'(lo) + longint'($urandom_range(32'(4 * FX_ONE))));
            end
        endcase
        case ($urandom_range(9))
            0:       step_val = '0;
            1:       step_val = 19'd1;
            2:       step_val = 19'h7ffff;
            3:       step_val = 19'd411775;
            default: step_val = 19'($urandom_range(411775, 1));
        endcase
        write_all(mode, off, up, lo, step_val);
        @(negedge i_clk);

        // random walk of position and velocity around the thresholds of the mode
        case (mode)
            OP_ENCODER: begin
                center = FX_4P2;
                stride = longint'(step_val) + 1;
            end
            OP_DAMPED: begin
                center = (longint'(up) + longint'(lo)) / 2;
                stride = longint'(up) - longint'(lo);
                if (stride < 0) begin
                    stride = -stride;
                end
                stride = stride / 2 + FX_ONE;
                if (stride > (longint'(1) << 30)) begin
                    stride = longint'(1) << 30;
                end
            end
            default: begin
                center = 0;
                stride = FX_ONE;
            end
        endcase
        walk_pos = center;
        walk_vel = ($urandom_range(1) != 0) ? 3 * FX_ONE / 2 : -3 * FX_ONE / 2;
        if ($urandom_range(9) != 0) begin
            push_req(CMD_START, 32'(walk_pos + longint'(off)), 32'(walk_vel));
        end
        for (k = 0; k < n_ticks; k++) begin
            if (pause_mid && k == n_ticks / 2) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_req(t_cmd'($urandom_range(1)), $urandom(), $urandom());
            end else if (pick < 11) begin
                push_req(CMD_START, 32'(walk_pos + longint'(off)), 32'(walk_vel));
            end else begin
                walk_pos += rand_span(stride);
                if (walk_pos > center + 8 * stride || walk_pos < center - 8 * stride) begin
                    walk_pos = center;
                end
                if (pick < 20) begin
                    walk_vel = -walk_vel;
                end else if (pick < 28) begin
                    case ($urandom_range(3))
                        0:       walk_vel = FX_ONE;
                        1:       walk_vel = FX_ONE + 1;
                        2:       walk_vel = -FX_ONE;
                        default: walk_vel = -FX_ONE - 1;
                    endcase
                end else begin
                    walk_vel += rand_span(2 * FX_0P3);
                end
                if (walk_vel > 4 * FX_ONE || walk_vel < -4 * FX_ONE) begin
                    walk_vel = 3 * FX_ONE / 2;
                end
                push_req(CMD_TICK, 32'(walk_pos + longint'(off)), 32'(walk_vel));
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 26)) begin
                next_req = pending_reqs.pop_front();
                req_if.valid             <= 1'b1;
                req_if.command           <= next_req.cmd;
                req_if.measured_angle    <= next_req.angle;
                req_if.measured_velocity <= next_req.velocity;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= no_gaps || ($urandom_range(99) >= 26);
        end
    end

    // result monitor; the accepted request is predicted after the check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_setpoints.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none actual setpoint %h",
                             $time, res_if.setpoint);
                end else begin
                    want = expected_setpoints.pop_front();
                    check_field("motor_enable", 32'(want.motor_enable), 32'(res_if.motor_enable));
                    check_field("drive_mode", 32'(want.drive_mode), 32'(res_if.drive_mode));
                    check_field("setpoint", want.setpoint, res_if.setpoint);
                    check_field("gain_profile", 32'(want.gain_profile), 32'(res_if.gain_profile));
                    check_field("detent_count", want.detent_count, res_if.detent_count);
                    check_field("position", want.position, res_if.position);
                end
            end
            if (req_if.valid && req_if.ready) begin
                predict_knob(t_cmd'(req_if.command), req_if.measured_angle,
                             req_if.measured_velocity);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic signed [31:0] half;
        int                 rand_count;
        int                 phase_no;
        int                 n;
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        req_if.valid             = 1'b0;
        req_if.command           = CMD_TICK;
        req_if.measured_angle    = '0;
        req_if.measured_velocity = '0;
        res_if.ready             = 1'b0;
        fail_count               = 0;
        idle_cycles              = 0;
        no_gaps                  = 1'b0;
        reset_knob_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, disabled
        push_req(CMD_TICK, 32'sh7fff_ffff, 32'sh7fff_ffff);
        push_req(CMD_TICK, 32'sh8000_0000, 32'sh8000_0000);
        push_req(CMD_START, '0, '0);

        // inertia around the 1 rad/s and 0.3 jump thresholds, position saturating high
        wait_drained();
        write_reg(REG_ZERO_OFFSET, 32'sh8000_0000);
        write_reg(REG_OPERATING_MODE, 32'(OP_INERTIA));
        @(negedge i_clk);
        push_req(CMD_START, 32'sh7fff_ffff, '0);
        push_req(CMD_TICK, 32'sh8000_0000, 32'sh7fff_ffff);
        push_req(CMD_TICK, '0, FX_ONE_S);
        push_req(CMD_TICK, '0, FX_ONE_S + 1);
        push_req(CMD_TICK, '0, FX_NEG_ONE_S - 1);
        push_req(CMD_TICK, '0, 32'(longint'(FX_NEG_ONE_S) - 1 - FX_0P3));
        push_req(CMD_TICK, '0, 32'sh8000_0000);

        // encoder exactly at and past half a detent both ways
        wait_drained();
        write_reg(REG_ZERO_OFFSET, '0);
        write_reg(REG_OPERATING_MODE, 32'(OP_ENCODER));
        @(negedge i_clk);
        half = 32'(FX_DETENT_S >> 1);
        push_req(CMD_START, '0, '0);
        push_req(CMD_TICK, FX_4P2_S + half, '0);
        push_req(CMD_TICK, FX_4P2_S + half + 1, '0);
        push_req(CMD_TICK, FX_4P2_S + 32'(FX_DETENT_S) - half, '0);
        push_req(CMD_TICK, FX_4P2_S + 32'(FX_DETENT_S) - half - 1, '0);

        // zero detent step: counts without moving the target
        wait_drained();
        write_reg(REG_DETENT_STEP, '0);
        @(negedge i_clk);
        push_req(CMD_TICK, FX_4P2_S + 1, '0);
        push_req(CMD_TICK, FX_4P2_S, '0);
        push_req(CMD_TICK, FX_4P2_S - 1, '0);

        // damped at the limits, then a disabled limit, then inverted limits
        wait_drained();
        write_reg(REG_DETENT_STEP, 32'(FX_DETENT_S));
        write_reg(REG_OPERATING_MODE, 32'(OP_DAMPED));
        @(negedge i_clk);
        push_req(CMD_START, '0, '0);
        push_req(CMD_TICK, FX_5P1_S + 1, '0);
        push_req(CMD_TICK, FX_5P1_S, '0);
        push_req(CMD_TICK, FX_3P3_S - 1, '0);
        push_req(CMD_TICK, FX_3P3_S, '0);
        wait_drained();
        write_reg(REG_LIMIT_UPPER, '0);
        @(negedge i_clk);
        push_req(CMD_TICK, FX_5P1_S + 1, '0);
        wait_drained();
        write_reg(REG_LIMIT_UPPER, FX_3P3_S);
        write_reg(REG_LIMIT_LOWER, FX_5P1_S);
        @(negedge i_clk);
        push_req(CMD_TICK, FX_4P2_S, '0);

        // fixed-target modes, mode change without start, unused codes
        wait_drained();
        write_reg(REG_OPERATING_MODE, 32'(OP_SPRING));
        @(negedge i_clk);
        push_req(CMD_START, '0, '0);
        push_req(CMD_TICK, 32'sh1234_5678, '0);
        wait_drained();
        write_reg(REG_OPERATING_MODE, 32'(OP_SPIN));
        @(negedge i_clk);
        push_req(CMD_START, '0, '0);
        push_req(CMD_TICK, '0, 32'sh7fff_ffff);
        wait_drained();
        write_reg(REG_OPERATING_MODE, 32'(OP_DAMPED));
        @(negedge i_clk);
        push_req(CMD_TICK, 32'sh7fff_ffff, '0);
        wait_drained();
        write_reg(REG_OPERATING_MODE, 32'd6);
        @(negedge i_clk);
        push_req(CMD_START, '0, '0);
        wait_drained();
        write_reg(REG_OPERATING_MODE, 32'd7);
        write_reg(REG_ZERO_OFFSET, 32'sh7fff_ffff);
        @(negedge i_clk);
        push_req(CMD_TICK, 32'sh8000_0000, '0);

        rand_count = 0;
        phase_no   = 0;
        while (rand_count < 300) begin
            if (phase_no == 2) begin
                // inertia parks the target at an end, then encoder ticks saturate there
                wait_drained();
                no_gaps = 1'b1;
                write_all(OP_INERTIA, '0, FX_5P1_S, FX_3P3_S, 19'h7ffff);
                @(negedge i_clk);
                push_req(CMD_START, '0, '0);
                push_req(CMD_TICK, '0, 32'sh7fff_ffff);
                wait_drained();
                write_reg(REG_OPERATING_MODE, 32'(OP_ENCODER));
                @(negedge i_clk);
                repeat (16) begin
                    push_req(CMD_TICK, 32'sh7fff_ffff, '0);
                    push_req(CMD_TICK, 32'sh8000_0000, '0);
                end
                wait_drained();
                write_reg(REG_OPERATING_MODE, 32'(OP_INERTIA));
                @(negedge i_clk);
                push_req(CMD_START, '0, '0);
                push_req(CMD_TICK, '0, 32'sh8000_0000);
                wait_drained();
                write_reg(REG_OPERATING_MODE, 32'(OP_ENCODER));
                @(negedge i_clk);
                repeat (16) begin
                    push_req(CMD_TICK, 32'sh8000_0000, '0);
                    push_req(CMD_TICK, 32'sh7fff_ffff, '0);
                end
                wait_drained();
                no_gaps = 1'b0;
            end
            n = $urandom_range(40, 8);
            if (phase_no == 5) begin
                no_gaps = 1'b1;
            end
            random_phase(n, phase_no == 3);
            if (phase_no == 5) begin
                wait_drained();
                no_gaps = 1'b0;
            end
            rand_count += n;
            phase_no++;
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && expected_setpoints.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hksg_pkg.sv
sv/hksg_if.sv
sv/hksg_cfg_regs.sv
sv/hksg_in_stage.sv
sv/hksg_update.sv
sv/haptic_knob_setpoint_generator_core.sv
bench/haptic_knob_setpoint_generator_core_tb.sv
